// ----- hw/rtl/sfc_pkg.sv -----
// Shared types and constants for the storage frame checker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sfc_pkg;

  // Header layout of a stored record frame.
  localparam int HEADER_BYTES = 10;

  // Position counter: 17 bits, saturating.
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MARKER1   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CHK_HI    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CHK_LO    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(8);
  localparam logic [POS_W-1:0] POS_MARKER2   = POS_W'(9);
  localparam logic [POS_W-1:0] POS_HDR_BYTES = POS_W'(HEADER_BYTES);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_SECOND = CFG_IDX_W'(1);

  // Frame status codes.
  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_SHORT    = 3'd1,
    STATUS_MARKER1  = 3'd2,
    STATUS_MARKER2  = 3'd3,
    STATUS_LENGTH   = 3'd4,
    STATUS_CHECKSUM = 3'd5
  } sfc_status_t;

  // One result item.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  data;
    logic        frame_done;
    sfc_status_t status;
  } sfc_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfc_frame_check.sv -----
// Frame state and per-byte check logic of the storage frame checker.
// Depends on sfc_pkg for the header layout, status codes and result type.
`default_nettype none

module sfc_frame_check
  import sfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_in,
  input  wire logic [7:0]  marker_first,
  input  wire logic [7:0]  marker_second,
  output sfc_result_t      result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [15:0]      chk_r, chk_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [1:0]       merr_r, merr_nxt;
  logic [POS_W-1:0] total;

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    chk_nxt  = chk_r;
    len_nxt  = len_r;
    merr_nxt = merr_r;
    result   = '{payload_valid: 1'b0, data: 8'h00, frame_done: 1'b0, status: STATUS_OK};

    unique case (pos_r)
      POS_MARKER1: begin
        if (byte_in != marker_first) merr_nxt[0] = 1'b1;
      end
      POS_CHK_HI: chk_nxt = {byte_in, 8'h00};
      POS_CHK_LO: chk_nxt = {chk_r[15:8], byte_in};
      POS_LEN_HI: len_nxt = {byte_in, 8'h00};
      POS_LEN_LO: len_nxt = {len_r[15:8], byte_in};
      POS_MARKER2: begin
        if (byte_in != marker_second) merr_nxt[1] = 1'b1;
      end
      default: begin
        if (pos_r >= POS_HDR_BYTES) begin
          result.payload_valid = 1'b1;
          result.data          = byte_in;
          sum_nxt              = sum_r + {8'h00, byte_in};
        end
      end
    endcase

    total = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;

    if (last_in) begin
      // Status uses the updated header fields so a last byte inside the
      // header still counts.
      result.frame_done = 1'b1;
      if (total < POS_HDR_BYTES) begin
        result.status = STATUS_SHORT;
      end else if (merr_nxt[0]) begin
        result.status = STATUS_MARKER1;
      end else if (merr_nxt[1]) begin
        result.status = STATUS_MARKER2;
      end else if ({1'b0, len_nxt} != total - POS_HDR_BYTES) begin
        result.status = STATUS_LENGTH;
      end else if (sum_nxt != chk_nxt) begin
        result.status = STATUS_CHECKSUM;
      end else begin
        result.status = STATUS_OK;
      end
      pos_nxt  = '0;
      sum_nxt  = '0;
      chk_nxt  = '0;
      len_nxt  = '0;
      merr_nxt = '0;
    end else begin
      pos_nxt = total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      chk_r  <= '0;
      len_r  <= '0;
      merr_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      chk_r  <= chk_nxt;
      len_r  <= len_nxt;
      merr_r <= merr_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfc_out_stage.sv -----
// Result register of the storage frame checker, holding one result until it is taken.
// Depends on sfc_pkg for the result type.
`default_nettype none

module sfc_out_stage
  import sfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire sfc_result_t result_in,
  input  wire logic        take,
  output logic             full,
  output sfc_result_t      result_out
);

  logic        full_r;
  sfc_result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (load) begin
      full_r <= 1'b1;
    end else if (take) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result_in;
    end
  end

  assign full       = full_r;
  assign result_out = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/storage_frame_checker.sv -----
// Storage frame checker: each byte passes through an input register and a result register.
// Throughput is one byte per cycle while out_tready holds, set by the single frame state
// update per byte. The two registers part the two stream sides, so a new byte is taken
// while a finished result waits. Reset (rst_n, synchronous, low) clears the frame state,
// both marker registers and all valid flags.
// Depends on sfc_pkg, sfc_frame_check and sfc_out_stage.
`default_nettype none

module storage_frame_checker
  import sfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream: one frame byte per transfer.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] in_byte
  input  wire logic                 in_tlast,   // in_last
  // Result stream: one result per input byte.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_tdata,  // [7:0] out_byte, [10:8] status, rest zero
  output logic                      out_tuser,  // out_valid
  output logic                      out_tlast,  // frame_done
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  // Marker registers. Writes to indexes beyond the list are accepted and dropped.
  logic [7:0] marker_first_r;
  logic [7:0] marker_second_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_first_r  <= '0;
      marker_second_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MARKER_FIRST) begin
        marker_first_r <= cfg_data;
      end else if (cfg_index == CFG_MARKER_SECOND) begin
        marker_second_r <= cfg_data;
      end
    end
  end

  // Input register. It advances into the checker whenever the result
  // register is empty or is being drained in the same cycle.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_full;
  logic       advance;

  assign advance   = s1_valid_r && (!out_full || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // The frame state moves exactly once per byte, at the cycle in which the
  // byte's result is loaded into the result register.
  sfc_result_t chk_result;
  sfc_result_t out_result;

  sfc_frame_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .byte_in       (s1_byte_r),
    .last_in       (s1_last_r),
    .marker_first  (marker_first_r),
    .marker_second (marker_second_r),
    .result        (chk_result)
  );

  sfc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result_in  (chk_result),
    .take       (out_tready),
    .full       (out_full),
    .result_out (out_result)
  );

  assign out_tvalid = out_full;
  assign out_tdata  = {5'b0, out_result.status, out_result.data};
  assign out_tuser  = out_result.payload_valid;
  assign out_tlast  = out_result.frame_done;

endmodule

`default_nettype wire

// ----- dv/sfc_result_monitor.sv -----
// Result monitor for the storage frame checker: watches the configuration, input and
// result channels, predicts each result and compares it. Depends on sfc_pkg.

module sfc_result_monitor
  import sfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  // Marker values the frame is held against, as last written.
  logic [7:0]       want_marker1;
  logic [7:0]       want_marker2;
  // State of the frame being received.
  logic [POS_W-1:0] frame_pos;
  logic [15:0]      payload_sum;
  logic [15:0]      header_sum;
  logic [15:0]      header_len;
  logic [1:0]       marker_bad;

  sfc_result_t      awaited_results[$];
  sfc_result_t      oldest;
  sfc_result_t      predicted;
  logic [15:0]      want_tdata;
  int               error_count;

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  // Advances the frame state by one byte and returns the result that byte causes.
  function automatic sfc_result_t advance_frame(input logic [7:0] b, input logic last);
    sfc_result_t      r;
    logic [POS_W-1:0] here;
    logic [POS_W-1:0] total;
    r.payload_valid = 1'b0;
    r.data          = 8'h00;
    r.frame_done    = 1'b0;
    r.status        = STATUS_OK;
    here = frame_pos;
    case (here)
      POS_MARKER1: if (b != want_marker1) marker_bad[0] = 1'b1;
      POS_CHK_HI:  header_sum = {b, 8'h00};
      POS_CHK_LO:  header_sum = {header_sum[15:8], b};
      POS_LEN_HI:  header_len = {b, 8'h00};
      POS_LEN_LO:  header_len = {header_len[15:8], b};
      POS_MARKER2: if (b != want_marker2) marker_bad[1] = 1'b1;
      default: begin
        // Nonce bytes fall through here and are dropped.
        if (here >= POS_HDR_BYTES) begin
          r.payload_valid = 1'b1;
          r.data          = b;
          payload_sum     = payload_sum + 16'(b);
        end
      end
    endcase
    total = (here < POS_MAX) ? here + 1'b1 : POS_MAX;
    if (last) begin
      r.frame_done = 1'b1;
      if (total < POS_HDR_BYTES)
        r.status = STATUS_SHORT;
      else if (marker_bad[0])
        r.status = STATUS_MARKER1;
      else if (marker_bad[1])
        r.status = STATUS_MARKER2;
      else if ({1'b0, header_len} != total - POS_HDR_BYTES)
        r.status = STATUS_LENGTH;
      else if (payload_sum != header_sum)
        r.status = STATUS_CHECKSUM;
      frame_pos   = '0;
      payload_sum = '0;
      header_sum  = '0;
      header_len  = '0;
      marker_bad  = '0;
    end else begin
      frame_pos = total;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      want_marker1 = '0;
      want_marker2 = '0;
      frame_pos    = '0;
      payload_sum  = '0;
      header_sum   = '0;
      header_len   = '0;
      marker_bad   = '0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MARKER_FIRST:  want_marker1 = cfg_data;
          CFG_MARKER_SECOND: want_marker2 = cfg_data;
          default: ;
        endcase
      end
      // Results leave before the byte taken at the same edge is predicted, so a
      // result can never be matched against an expectation created in the same cycle.
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          if (error_count < 10)
            $display("[%0t] result with nothing outstanding: tdata=%04h tuser=%0b tlast=%0b",
                     $time, out_tdata, out_tuser, out_tlast);
          error_count++;
        end else begin
          oldest     = awaited_results.pop_front();
          want_tdata = {5'b00000, oldest.status, oldest.data};
          if (out_tdata !== want_tdata || out_tuser !== oldest.payload_valid ||
              out_tlast !== oldest.frame_done) begin
            if (error_count < 10)
              $display("[%0t] mismatch (tuser/tdata/tlast): expected %0b/%04h/%0b, got %0b/%04h/%0b",
                       $time, oldest.payload_valid, want_tdata, oldest.frame_done,
                       out_tuser, out_tdata, out_tlast);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted = advance_frame(in_tdata, in_tlast);
        awaited_results.insert(awaited_results.size(), predicted);
      end
    end
    awaited    = awaited_results.size();
    mismatches = error_count;
  end

endmodule

// ----- dv/tb_storage_frame_checker.sv -----
// Top of the storage frame checker testbench: clock, reset, frame stimulus and verdict.
// Depends on sfc_pkg, storage_frame_checker and sfc_result_monitor.

module tb_storage_frame_checker;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Random bytes wanted after the directed frames.
  localparam int RANDOM_BYTES = 750;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic [7:0]           in_tdata = 8'h00;
  logic                 in_tlast = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [15:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_ready;
  int                   mismatches;
  int                   awaited;

  // When set, neither side inserts gaps.
  bit                   calm = 1'b0;
  int                   stall_left = 0;
  int                   quiet_cycles = 0;
  // Markers as the block currently holds them, so that good frames can be built.
  logic [7:0]           cur_marker1 = 8'h00;
  logic [7:0]           cur_marker2 = 8'h00;
  logic [7:0]           frame_bytes[$];
  int                   bytes_sent = 0;
  int                   frames_sent = 0;
  int                   reg_writes = 0;

  storage_frame_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfc_result_monitor monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap lengths: mostly short, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // The result side stalls at random; a stall starts in about a quarter of the
  // cycles in which it is ready, except in calm stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        stall_left <= pick_gap();
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results still outstanding",
                 quiet_cycles, awaited);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one byte, maybe after a gap, and returns at the edge of its transfer.
  // in_tvalid stays high afterwards so back-to-back bytes need no second assignment.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Sends frame_bytes[from .. upto-1]; the final byte of the queue carries tlast
  // when closes is set.
  task automatic send_range(input int from, input int upto, input bit closes);
    for (int i = from; i < upto; i++)
      send_byte(frame_bytes[i], closes && i == frame_bytes.size() - 1);
    if (closes)
      frames_sent++;
  endtask

  // Stops the input and waits for every outstanding result, then idles
  // for a margin before returning.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (2) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MARKER_FIRST)
      cur_marker1 = val;
    else if (idx == CFG_MARKER_SECOND)
      cur_marker2 = val;
    reg_writes++;
  endtask

  // Appends one byte to the frame being built.
  task automatic add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  // Builds a complete frame with n_payload random payload bytes. Each bit of
  // corrupt spoils one header field: 0 first marker, 1 second marker, 2 length,
  // 3 checksum. A spoiled field always differs from the good value.
  task automatic build_frame(input int n_payload, input logic [3:0] corrupt);
    logic [7:0]  payload[$];
    logic [15:0] sum;
    logic [15:0] len;
    logic [7:0]  b;
    sum = '0;
    for (int i = 0; i < n_payload; i++) begin
      b = 8'($urandom);
      payload.insert(payload.size(), b);
      sum = sum + 16'(b);
    end
    if (corrupt[3])
      sum = sum ^ 16'($urandom_range(1, 65535));
    len = corrupt[2] ? 16'(n_payload) ^ 16'($urandom_range(1, 65535)) : 16'(n_payload);
    frame_bytes.delete();
    add_byte(corrupt[0] ? cur_marker1 ^ 8'($urandom_range(1, 255)) : cur_marker1);
    add_byte(sum[15:8]);
    add_byte(sum[7:0]);
    repeat (4) add_byte(8'($urandom));
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    add_byte(corrupt[1] ? cur_marker2 ^ 8'($urandom_range(1, 255)) : cur_marker2);
    foreach (payload[i])
      add_byte(payload[i]);
  endtask

  initial begin
    int          target;
    int          pick;
    int          n_payload;
    int          keep;
    logic [3:0]  corrupt;
    logic [7:0]  val;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A good frame with no payload against the reset markers.
    build_frame(0, 4'b0000);
    send_range(0, frame_bytes.size(), 1'b1);
    // A frame that is a single byte: the first marker is also the last byte.
    send_byte(cur_marker1, 1'b1);
    frames_sent++;
    // Both markers at the top of their range.
    write_reg(CFG_MARKER_FIRST, 8'hFF);
    write_reg(CFG_MARKER_SECOND, 8'hFF);
    // Register change in mid-frame: the frame is built with a bad second marker,
    // then the register is rewritten to match before that header byte arrives,
    // so the frame ends good.
    build_frame(1, 4'b0010);
    send_range(0, 5, 1'b0);
    write_reg(CFG_MARKER_SECOND, frame_bytes[9]);
    send_range(5, frame_bytes.size(), 1'b1);

    // Random part: mostly well-formed frames with random content and the odd
    // spoiled field, mixed with short frames and plain noise.
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 99) < 7) begin
        // Register phase: extremes, random values and now and then an unused index.
        pick = $urandom_range(0, 3);
        val  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        if ($urandom_range(0, 9) == 0)
          write_reg(CFG_IDX_W'($urandom_range(2, 255)), val);
        else
          write_reg($urandom_range(0, 1) ? CFG_MARKER_SECOND : CFG_MARKER_FIRST, val);
      end
      calm = ($urandom_range(0, 4) == 0);
      n_payload = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        corrupt = '0;
        for (int i = 0; i < 4; i++)
          corrupt[i] = ($urandom_range(0, 9) == 0);
        build_frame(n_payload, corrupt);
      end else if (pick < 86) begin
        // Frame cut off inside the header, possibly with spoiled fields too.
        build_frame(n_payload, 4'($urandom));
        keep = $urandom_range(1, HEADER_BYTES - 1);
        while (frame_bytes.size() > keep)
          void'(frame_bytes.pop_back());
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
      end
      send_range(0, frame_bytes.size(), 1'b1);
    end

    calm = 1'b1;
    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d frames in %0d bytes with %0d register writes,", frames_sent,
             bytes_sent, reg_writes);
    $display("including short, corrupt and noise frames and a mid-frame marker change.");
    if (mismatches == 0 && awaited == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, awaited);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- storage_frame_checker.f -----
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_frame_check.sv
hw/rtl/sfc_out_stage.sv
hw/rtl/storage_frame_checker.sv
dv/sfc_result_monitor.sv
dv/tb_storage_frame_checker.sv
